FILE: sv/loop_pedal_mode_controller_core_assert.svh
// assertion macros shared by the looper controller
`ifndef LOOP_PEDAL_MODE_CONTROLLER_CORE_ASSERT_SVH
`define LOOP_PEDAL_MODE_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LPMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define LPMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/lpmc_pkg.sv
`timescale 1ns / 1ps
package lpmc_pkg;

	localparam int TRACKS        = 4;
	localparam int DURATION_BITS = 24;

	localparam int NOTE_W  = 7;
	localparam int FUNC_W  = 2;
	localparam int TRK_W   = 2;
	localparam int MASK_W  = 4;
	localparam int LEN_W   = 24;
	localparam int CMD_W   = 3;
	localparam int CFG_IDX_W = 3;

	localparam logic [MASK_W-1:0] TRACK_MASK = MASK_W'((1 << TRACKS) - 1);
	localparam logic [LEN_W-1:0]  DUR_MAX    = (DURATION_BITS >= LEN_W) ? {LEN_W{1'b1}} :
		LEN_W'((64'd1 << DURATION_BITS) - 64'd1);

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_RECORD_PLAY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_STOP        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_MODE        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_CLEAR       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_FIRST_TRACK = 3'd4;

	// input message codes
	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_NOTE = 2'd1;

	typedef enum logic [1:0] {
		MODE_PLAY = 2'd0,
		MODE_PIR  = 2'd1,
		MODE_REC  = 2'd2,
		MODE_ODUB = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_STARTED = 2'd1,
		ST_DONE    = 2'd2
	} rec_st_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE      = 3'd0,
		CMD_PLAY_ALL  = 3'd1,
		CMD_RESET_ALL = 3'd2,
		CMD_CLEAR_SEL = 3'd3,
		CMD_SET_LEN   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_NOTE = 2'd1,
		OP_BAD  = 2'd2
	} op_kind_t;

	// classified item as it travels through the queue
	typedef struct packed {
		op_kind_t         kind;
		logic             hit_rec;
		logic             hit_stop;
		logic             hit_mode;
		logic             hit_clear;
		logic             hit_track;
		logic [TRK_W-1:0] track;
	} op_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_TICK,
		ACT_BAD,
		ACT_PLAY_ALL,
		ACT_GMUTE,
		ACT_TO_PIR,
		ACT_RESET_ALL,
		ACT_TOGGLE_TRACK,
		ACT_START_REC,
		ACT_TO_ODUB,
		ACT_CAPTURE,
		ACT_TO_PLAY,
		ACT_TOGGLE_SEL,
		ACT_CLEAR_SEL,
		ACT_SELECT
	} act_t;

endpackage

FILE: sv/lpmc_front.sv
`timescale 1ns / 1ps
module lpmc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpmc_pkg::NOTE_W-1:0]     cfg_data,
	input  logic [lpmc_pkg::FUNC_W-1:0]     func,
	input  logic [lpmc_pkg::NOTE_W-1:0]     note,
	output lpmc_pkg::op_t                   op
);

	logic [lpmc_pkg::NOTE_W-1:0] note_rec_q, note_stop_q, note_mode_q, note_clear_q, note_first_q;
	logic [lpmc_pkg::NOTE_W:0]   diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_rec_q   <= 7'd60;
			note_stop_q  <= 7'd61;
			note_mode_q  <= 7'd62;
			note_clear_q <= 7'd63;
			note_first_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				lpmc_pkg::CFG_NOTE_RECORD_PLAY: note_rec_q   <= cfg_data;
				lpmc_pkg::CFG_NOTE_STOP:        note_stop_q  <= cfg_data;
				lpmc_pkg::CFG_NOTE_MODE:        note_mode_q  <= cfg_data;
				lpmc_pkg::CFG_NOTE_CLEAR:       note_clear_q <= cfg_data;
				lpmc_pkg::CFG_NOTE_FIRST_TRACK: note_first_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// msb of the difference is the borrow: note below the first track button
	assign diff = {1'b0, note} - {1'b0, note_first_q};

	always_comb begin
		case (func)
			lpmc_pkg::FUNC_TICK: op.kind = lpmc_pkg::OP_TICK;
			lpmc_pkg::FUNC_NOTE: op.kind = lpmc_pkg::OP_NOTE;
			default:             op.kind = lpmc_pkg::OP_BAD;
		endcase
		op.hit_rec   = (note == note_rec_q);
		op.hit_stop  = (note == note_stop_q);
		op.hit_mode  = (note == note_mode_q);
		op.hit_clear = (note == note_clear_q);
		op.hit_track = !diff[lpmc_pkg::NOTE_W] &&
			(diff < (lpmc_pkg::NOTE_W+1)'(lpmc_pkg::TRACKS));
		op.track     = diff[lpmc_pkg::TRK_W-1:0];
	end

endmodule

FILE: sv/lpmc_queue.sv
`timescale 1ns / 1ps
module lpmc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lpmc_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output lpmc_pkg::op_t head_op
);

	lpmc_pkg::op_t                entries_q [lpmc_pkg::Q_DEPTH];
	logic [lpmc_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [lpmc_pkg::Q_CNT_W-1:0] count_q;

	assign full     = (count_q == lpmc_pkg::Q_CNT_W'(lpmc_pkg::Q_DEPTH));
	assign nonempty = (count_q != '0);
	assign head_op  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: sv/lpmc_back.sv
`timescale 1ns / 1ps
module lpmc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         op_valid,
	input  lpmc_pkg::op_t                op,
	output logic                         op_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   loop_mode,
	output logic [1:0]                   rec_status,
	output logic [lpmc_pkg::TRK_W-1:0]   current_track,
	output logic [lpmc_pkg::MASK_W-1:0]  mute_mask,
	output logic                         all_muted,
	output logic                         input_bypass,
	output logic [lpmc_pkg::CMD_W-1:0]   track_cmd,
	output logic [lpmc_pkg::LEN_W-1:0]   loop_length_ms,
	output logic                         bad_message
);

	lpmc_pkg::mode_t              mode_q, mode_d;
	lpmc_pkg::rec_st_t            status_q, status_d;
	logic [lpmc_pkg::TRK_W-1:0]   sel_q, sel_d;
	logic [lpmc_pkg::MASK_W-1:0]  mute_q, mute_d;
	logic                         gmute_q, gmute_d;
	logic [lpmc_pkg::LEN_W-1:0]   elapsed_q, elapsed_d;
	lpmc_pkg::act_t               act;
	lpmc_pkg::cmd_t               cmd;
	logic [lpmc_pkg::LEN_W-1:0]   len;
	logic                         emit;
	logic                         can_emit;
	logic                         out_valid_q;
	logic [1:0]                   mode_out_q, status_out_q;
	logic [lpmc_pkg::TRK_W-1:0]   sel_out_q;
	logic [lpmc_pkg::MASK_W-1:0]  mute_out_q;
	logic                         gmute_out_q, bypass_out_q, bad_out_q;
	logic [lpmc_pkg::CMD_W-1:0]   cmd_out_q;
	logic [lpmc_pkg::LEN_W-1:0]   len_out_q;

	// output register is free or drains this cycle; ticks never need it
	assign can_emit = !out_valid_q || out_ready;
	assign op_pop   = op_valid && ((op.kind == lpmc_pkg::OP_TICK) || can_emit);

	// button priority resolution
	always_comb begin
		act = lpmc_pkg::ACT_NONE;
		case (op.kind)
			lpmc_pkg::OP_TICK: act = lpmc_pkg::ACT_TICK;
			lpmc_pkg::OP_NOTE: begin
				if (mode_q == lpmc_pkg::MODE_PLAY) begin
					if (op.hit_rec)        act = lpmc_pkg::ACT_PLAY_ALL;
					else if (op.hit_stop)  act = lpmc_pkg::ACT_GMUTE;
					else if (op.hit_mode)  act = lpmc_pkg::ACT_TO_PIR;
					else if (op.hit_clear) act = lpmc_pkg::ACT_RESET_ALL;
					else if (op.hit_track) act = lpmc_pkg::ACT_TOGGLE_TRACK;
				end else begin
					if (op.hit_rec) begin
						case (mode_q)
							lpmc_pkg::MODE_PIR: act = (status_q == lpmc_pkg::ST_NONE) ?
								lpmc_pkg::ACT_START_REC : lpmc_pkg::ACT_TO_ODUB;
							lpmc_pkg::MODE_REC: act = (status_q == lpmc_pkg::ST_STARTED) ?
								lpmc_pkg::ACT_CAPTURE : lpmc_pkg::ACT_NONE;
							default:            act = lpmc_pkg::ACT_TO_PIR;
						endcase
					end
					else if (op.hit_mode)  act = lpmc_pkg::ACT_TO_PLAY;
					else if (op.hit_stop)  act = lpmc_pkg::ACT_TOGGLE_SEL;
					else if (op.hit_clear) act = lpmc_pkg::ACT_CLEAR_SEL;
					else if (op.hit_track) act = lpmc_pkg::ACT_SELECT;
				end
			end
			default: act = lpmc_pkg::ACT_BAD;
		endcase
	end

	// next state
	always_comb begin
		mode_d    = mode_q;
		status_d  = status_q;
		sel_d     = sel_q;
		mute_d    = mute_q;
		gmute_d   = gmute_q;
		elapsed_d = elapsed_q;
		case (act)
			lpmc_pkg::ACT_TICK: begin
				if (status_q == lpmc_pkg::ST_STARTED && elapsed_q < lpmc_pkg::DUR_MAX)
					elapsed_d = elapsed_q + 1'b1;
			end
			lpmc_pkg::ACT_PLAY_ALL:     gmute_d = 1'b0;
			lpmc_pkg::ACT_GMUTE:        gmute_d = 1'b1;
			lpmc_pkg::ACT_TO_PIR:       mode_d  = lpmc_pkg::MODE_PIR;
			lpmc_pkg::ACT_RESET_ALL: begin
				sel_d     = '0;
				elapsed_d = '0;
				status_d  = lpmc_pkg::ST_NONE;
				mute_d    = '0;
				mode_d    = lpmc_pkg::MODE_PIR;
			end
			lpmc_pkg::ACT_TOGGLE_TRACK: mute_d = mute_q ^ (lpmc_pkg::MASK_W'(1) << op.track);
			lpmc_pkg::ACT_START_REC: begin
				elapsed_d = '0;
				status_d  = lpmc_pkg::ST_STARTED;
				mode_d    = lpmc_pkg::MODE_REC;
			end
			lpmc_pkg::ACT_TO_ODUB:      mode_d = lpmc_pkg::MODE_ODUB;
			lpmc_pkg::ACT_CAPTURE: begin
				status_d = lpmc_pkg::ST_DONE;
				mode_d   = lpmc_pkg::MODE_ODUB;
			end
			lpmc_pkg::ACT_TO_PLAY:      mode_d = lpmc_pkg::MODE_PLAY;
			lpmc_pkg::ACT_TOGGLE_SEL:   mute_d = mute_q ^ (lpmc_pkg::MASK_W'(1) << sel_q);
			lpmc_pkg::ACT_SELECT: begin
				sel_d = op.track;
				if (mode_q == lpmc_pkg::MODE_REC) begin
					if (status_q == lpmc_pkg::ST_STARTED)
						status_d = lpmc_pkg::ST_DONE;
					mode_d = lpmc_pkg::MODE_ODUB;
				end else if (mode_q == lpmc_pkg::MODE_ODUB && sel_q == op.track) begin
					mode_d = lpmc_pkg::MODE_PIR;
				end
			end
			default: ;
		endcase
		mute_d = mute_d & lpmc_pkg::TRACK_MASK;
	end

	// result fields
	always_comb begin
		emit = (act != lpmc_pkg::ACT_TICK);
		cmd  = lpmc_pkg::CMD_NONE;
		len  = '0;
		case (act)
			lpmc_pkg::ACT_PLAY_ALL:  cmd = lpmc_pkg::CMD_PLAY_ALL;
			lpmc_pkg::ACT_RESET_ALL: cmd = lpmc_pkg::CMD_RESET_ALL;
			lpmc_pkg::ACT_CLEAR_SEL: cmd = lpmc_pkg::CMD_CLEAR_SEL;
			lpmc_pkg::ACT_CAPTURE: begin
				cmd = lpmc_pkg::CMD_SET_LEN;
				len = elapsed_q;
			end
			lpmc_pkg::ACT_SELECT: begin
				if (mode_q == lpmc_pkg::MODE_REC && status_q == lpmc_pkg::ST_STARTED) begin
					cmd = lpmc_pkg::CMD_SET_LEN;
					len = elapsed_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= lpmc_pkg::MODE_PIR;
			status_q    <= lpmc_pkg::ST_NONE;
			sel_q       <= '0;
			mute_q      <= '0;
			gmute_q     <= 1'b0;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op_pop) begin
				mode_q    <= mode_d;
				status_q  <= status_d;
				sel_q     <= sel_d;
				mute_q    <= mute_d;
				gmute_q   <= gmute_d;
				elapsed_q <= elapsed_d;
			end
			if (op_pop && emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && emit) begin
			mode_out_q   <= mode_d;
			status_out_q <= status_d;
			sel_out_q    <= sel_d;
			mute_out_q   <= mute_d;
			gmute_out_q  <= gmute_d;
			bypass_out_q <= (mode_d == lpmc_pkg::MODE_PLAY) || (mode_d == lpmc_pkg::MODE_PIR);
			cmd_out_q    <= cmd;
			len_out_q    <= len;
			bad_out_q    <= (act == lpmc_pkg::ACT_BAD);
		end
	end

	assign out_valid      = out_valid_q;
	assign loop_mode      = mode_out_q;
	assign rec_status     = status_out_q;
	assign current_track  = sel_out_q;
	assign mute_mask      = mute_out_q;
	assign all_muted      = gmute_out_q;
	assign input_bypass   = bypass_out_q;
	assign track_cmd      = cmd_out_q;
	assign loop_length_ms = len_out_q;
	assign bad_message    = bad_out_q;

endmodule

FILE: sv/loop_pedal_mode_controller_core.sv
`timescale 1ns / 1ps
// looper pedal mode controller
// input channel: in_valid/in_ready with func (tick, note-on, other) and note.
// output channel: out_valid/out_ready with the new looper state, the muter
// bypass, one track command and the captured loop length.
// config port: cfg_we/cfg_index/cfg_data set the button note numbers; write
// only while no item is in flight.
// a front stage compares the note against the button registers, a two-entry
// queue holds the classified item, the back stage applies the button rules and
// loads the output register.
// an accepted item goes into the queue, then the back stage loads its result.
// throughput: one item per cycle if out_ready; ticks update the counter, no item.
// when the receiver stalls the output register holds, the queue fills and
// in_ready drops once both entries are taken.
// reset: play in record mode, nothing recorded, track 0, all unmuted, counter
// cleared, button notes 60 to 64; the block is ready right after reset.
module loop_pedal_mode_controller_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpmc_pkg::NOTE_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lpmc_pkg::FUNC_W-1:0]     func,
	input  logic [lpmc_pkg::NOTE_W-1:0]     note,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      loop_mode,
	output logic [1:0]                      rec_status,
	output logic [lpmc_pkg::TRK_W-1:0]      current_track,
	output logic [lpmc_pkg::MASK_W-1:0]     mute_mask,
	output logic                            all_muted,
	output logic                            input_bypass,
	output logic [lpmc_pkg::CMD_W-1:0]      track_cmd,
	output logic [lpmc_pkg::LEN_W-1:0]      loop_length_ms,
	output logic                            bad_message
);

	`include "loop_pedal_mode_controller_core_assert.svh"

	lpmc_pkg::op_t front_op, head_op;
	logic          q_full, q_nonempty, q_pop, push;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	lpmc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.func      (func),
		.note      (note),
		.op        (front_op)
	);

	lpmc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (front_op),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head_op  (head_op)
	);

	lpmc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.op_valid       (q_nonempty),
		.op             (head_op),
		.op_pop         (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.loop_mode      (loop_mode),
		.rec_status     (rec_status),
		.current_track  (current_track),
		.mute_mask      (mute_mask),
		.all_muted      (all_muted),
		.input_bypass   (input_bypass),
		.track_cmd      (track_cmd),
		.loop_length_ms (loop_length_ms),
		.bad_message    (bad_message)
	);

	`LPMC_ASSERT_NOW(a_capture_state, out_valid && track_cmd == lpmc_pkg::CMD_SET_LEN, rec_status == lpmc_pkg::ST_DONE && loop_mode == lpmc_pkg::MODE_ODUB, "capture without recorded overdub state")
	`LPMC_ASSERT_NOW(a_len_only_capture, out_valid && track_cmd != lpmc_pkg::CMD_SET_LEN, loop_length_ms == '0, "loop length outside capture command")
	`LPMC_ASSERT_NOW(a_bad_no_cmd, out_valid && bad_message, track_cmd == lpmc_pkg::CMD_NONE, "command issued with bad message")
	`LPMC_ASSERT_NEXT(a_full_stalls_out, q_full && !q_pop, q_nonempty, "queue lost items while stalled")

endmodule

FILE: verif/looper_checker.sv
`timescale 1ns / 1ps
module looper_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpmc_pkg::NOTE_W-1:0]     cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [lpmc_pkg::FUNC_W-1:0]     func,
	input  logic [lpmc_pkg::NOTE_W-1:0]     note,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [1:0]                      loop_mode,
	input  logic [1:0]                      rec_status,
	input  logic [lpmc_pkg::TRK_W-1:0]      current_track,
	input  logic [lpmc_pkg::MASK_W-1:0]     mute_mask,
	input  logic                            all_muted,
	input  logic                            input_bypass,
	input  logic [lpmc_pkg::CMD_W-1:0]      track_cmd,
	input  logic [lpmc_pkg::LEN_W-1:0]      loop_length_ms,
	input  logic                            bad_message,
	output int                              fail_count,
	output int                              expected_left
);
	import lpmc_pkg::*;

	typedef struct packed {
		mode_t              mode;
		rec_st_t            status;
		logic [TRK_W-1:0]   track;
		logic [MASK_W-1:0]  mask;
		logic               gmute;
		logic               bypass;
		cmd_t               cmd;
		logic [LEN_W-1:0]   len;
		logic               bad;
	} looper_state_out_t;

	// button note numbers as last written
	logic [NOTE_W-1:0] btn_rec, btn_stop, btn_mode, btn_clear, btn_first;

	mode_t             mode;
	rec_st_t           status;
	logic [TRK_W-1:0]  sel;
	logic [MASK_W-1:0] mutes;
	logic              gmute;
	logic [LEN_W-1:0]  elapsed;

	looper_state_out_t state_q[$];
	int mismatches = 0;
	int waiting = 0;

	assign fail_count = mismatches;
	assign expected_left = waiting;

	// advance the looper by one item; returns 1 when the item gives a result
	function automatic bit advance_looper(input logic [FUNC_W-1:0] f,
			input logic [NOTE_W-1:0] n, output looper_state_out_t r);
		int d;
		bit is_trk;
		logic [TRK_W-1:0] trk;
		logic [TRK_W-1:0] prev;
		cmd_t cmd;
		logic [LEN_W-1:0] len;
		logic bad;
		d = int'(n) - int'(btn_first);
		is_trk = (d >= 0) && (d < TRACKS);
		trk = TRK_W'(d);
		cmd = CMD_NONE;
		len = '0;
		bad = 1'b0;
		r = '0;
		if (f == FUNC_TICK) begin
			if (status == ST_STARTED && elapsed != DUR_MAX)
				elapsed = elapsed + 1'b1;
			return 1'b0;
		end
		if (f != FUNC_NOTE) begin
			bad = 1'b1;
		end else if (mode == MODE_PLAY) begin
			if (n == btn_rec) begin
				gmute = 1'b0;
				cmd = CMD_PLAY_ALL;
			end else if (n == btn_stop) begin
				gmute = 1'b1;
			end else if (n == btn_mode) begin
				mode = MODE_PIR;
			end else if (n == btn_clear) begin
				sel = '0;
				elapsed = '0;
				status = ST_NONE;
				mutes = '0;
				mode = MODE_PIR;
				cmd = CMD_RESET_ALL;
			end else if (is_trk) begin
				mutes[trk] = ~mutes[trk];
			end
		end else begin
			if (n == btn_rec) begin
				if (mode == MODE_PIR) begin
					if (status == ST_NONE) begin
						elapsed = '0;
						status = ST_STARTED;
						mode = MODE_REC;
					end else begin
						mode = MODE_ODUB;
					end
				end else if (mode == MODE_REC) begin
					if (status == ST_STARTED) begin
						len = elapsed;
						cmd = CMD_SET_LEN;
						status = ST_DONE;
						mode = MODE_ODUB;
					end
				end else begin
					mode = MODE_PIR;
				end
			end else if (n == btn_mode) begin
				mode = MODE_PLAY;
			end else if (n == btn_stop) begin
				mutes[sel] = ~mutes[sel];
			end else if (n == btn_clear) begin
				cmd = CMD_CLEAR_SEL;
			end else if (is_trk) begin
				prev = sel;
				sel = trk;
				if (mode == MODE_REC) begin
					// selecting a track ends the first recording
					if (status == ST_STARTED) begin
						len = elapsed;
						cmd = CMD_SET_LEN;
						status = ST_DONE;
					end
					mode = MODE_ODUB;
				end else if (mode == MODE_ODUB && prev == sel) begin
					mode = MODE_PIR;
				end
			end
		end
		mutes = mutes & TRACK_MASK;
		r.mode = mode;
		r.status = status;
		r.track = sel;
		r.mask = mutes;
		r.gmute = gmute;
		r.bypass = (mode == MODE_PLAY || mode == MODE_PIR);
		r.cmd = cmd;
		r.len = len;
		r.bad = bad;
		return 1'b1;
	endfunction

	task automatic compare_field(input string what, input logic [LEN_W-1:0] want,
			input logic [LEN_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		looper_state_out_t want;
		looper_state_out_t fresh;
		if (!arst_n) begin
			btn_rec = 7'd60;
			btn_stop = 7'd61;
			btn_mode = 7'd62;
			btn_clear = 7'd63;
			btn_first = 7'd64;
			mode = MODE_PIR;
			status = ST_NONE;
			sel = '0;
			mutes = '0;
			gmute = 1'b0;
			elapsed = '0;
			state_q.delete();
			waiting = 0;
		end else begin
			// results first, so an item accepted now cannot match an older result
			if (out_valid && out_ready) begin
				if (state_q.size() == 0) begin
					$display("%0t ns: result with none expected, expected nothing, actual cmd %0d",
						$time, track_cmd);
					mismatches++;
				end else begin
					want = state_q.pop_front();
					compare_field("loop_mode", want.mode, loop_mode);
					compare_field("rec_status", want.status, rec_status);
					compare_field("current_track", want.track, current_track);
					compare_field("mute_mask", want.mask, mute_mask);
					compare_field("all_muted", want.gmute, all_muted);
					compare_field("input_bypass", want.bypass, input_bypass);
					compare_field("track_cmd", want.cmd, track_cmd);
					compare_field("loop_length_ms", want.len, loop_length_ms);
					compare_field("bad_message", want.bad, bad_message);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_NOTE_RECORD_PLAY: btn_rec = cfg_data;
					CFG_NOTE_STOP:        btn_stop = cfg_data;
					CFG_NOTE_MODE:        btn_mode = cfg_data;
					CFG_NOTE_CLEAR:       btn_clear = cfg_data;
					CFG_NOTE_FIRST_TRACK: btn_first = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (advance_looper(func, note, fresh))
					state_q.push_back(fresh);
			end
			waiting = state_q.size();
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import lpmc_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_PAD = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int ITEMS_PER_PHASE = 115;
	localparam logic [FUNC_W-1:0] FUNC_OTHER = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_OTHER_HI = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [NOTE_W-1:0]      cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [FUNC_W-1:0]      func;
	logic [NOTE_W-1:0]      note;
	logic                   out_valid;
	logic                   out_ready;
	logic [1:0]             loop_mode;
	logic [1:0]             rec_status;
	logic [TRK_W-1:0]       current_track;
	logic [MASK_W-1:0]      mute_mask;
	logic                   all_muted;
	logic                   input_bypass;
	logic [CMD_W-1:0]       track_cmd;
	logic [LEN_W-1:0]       loop_length_ms;
	logic                   bad_message;
	int                     fail_count;
	int                     expected_left;

	int cycle_cnt = 0;
	bit no_gaps = 1'b0;
	bit hold_off = 1'b0;
	logic [NOTE_W-1:0] btn_rec = 7'd60;
	logic [NOTE_W-1:0] btn_stop = 7'd61;
	logic [NOTE_W-1:0] btn_mode = 7'd62;
	logic [NOTE_W-1:0] btn_clear = 7'd63;
	logic [NOTE_W-1:0] btn_first = 7'd64;

	loop_pedal_mode_controller_core uut (.*);
	looper_checker chk (.*);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [NOTE_W-1:0] any_note();
		return NOTE_W'($urandom_range(0, 127));
	endfunction

	// button presses weighted so that recordings complete and modes cycle
	function automatic logic [NOTE_W-1:0] pick_note();
		int r;
		int span;
		r = $urandom_range(0, 99);
		span = 128 - int'(btn_first);
		if (span > TRACKS)
			span = TRACKS;
		if (r < 30)
			return btn_rec;
		if (r < 42)
			return btn_stop;
		if (r < 56)
			return btn_mode;
		if (r < 63)
			return btn_clear;
		if (r < 90)
			return NOTE_W'(int'(btn_first) + $urandom_range(0, span - 1));
		return any_note();
	endfunction

	// receiver side
	initial begin : sink
		int gap;
		gap = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				gap--;
			end else begin
				out_ready <= 1'b1;
				gap = gap_len();
			end
		end
	end

	task automatic push_item(input logic [FUNC_W-1:0] f, input logic [NOTE_W-1:0] n);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		note <= n;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic press(input logic [NOTE_W-1:0] n);
		push_item(FUNC_NOTE, n);
	endtask

	task automatic ticks(input int count);
		repeat (count) push_item(FUNC_TICK, any_note());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic set_buttons(input logic [NOTE_W-1:0] r, input logic [NOTE_W-1:0] s,
			input logic [NOTE_W-1:0] m, input logic [NOTE_W-1:0] c,
			input logic [NOTE_W-1:0] t);
		btn_rec = r;
		btn_stop = s;
		btn_mode = m;
		btn_clear = c;
		btn_first = t;
		cfg_we <= 1'b1;
		cfg_index <= CFG_NOTE_RECORD_PLAY;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= CFG_NOTE_STOP;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= CFG_NOTE_MODE;
		cfg_data <= m;
		@(posedge clk);
		cfg_index <= CFG_NOTE_CLEAR;
		cfg_data <= c;
		@(posedge clk);
		cfg_index <= CFG_NOTE_FIRST_TRACK;
		cfg_data <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(input int count);
		int done;
		int r;
		int burst;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				push_item(r[0] ? FUNC_OTHER : FUNC_OTHER_HI, any_note());
				done++;
			end else if (r < 30) begin
				// long tick bursts give loop lengths of some size
				burst = (r < 8) ? $urandom_range(10, 60) : $urandom_range(1, 4);
				ticks(burst);
				done += burst;
			end else begin
				press(pick_note());
				done++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_TICK;
		note = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk through the button rules at the reset note numbers
		push_item(FUNC_OTHER, 7'd0);
		push_item(FUNC_OTHER_HI, 7'd127);
		press(7'd0);
		press(7'd127);
		press(btn_rec);
		ticks(5);
		press(btn_first);
		press(btn_first);
		press(btn_stop);
		press(btn_clear);
		press(btn_rec);
		press(btn_first + 7'd1);
		press(btn_rec);
		press(btn_mode);
		press(btn_rec);
		press(btn_stop);
		press(btn_first + 7'd3);
		press(btn_mode);
		press(btn_mode);
		press(btn_clear);
		press(btn_rec);
		ticks(3);
		press(btn_rec);
		press(btn_rec);
		// a recording that is stopped without a single tick
		press(btn_mode);
		press(btn_clear);
		press(btn_rec);
		press(btn_rec);
		drain();

		// receiver holds off long enough to back up the input
		set_buttons(7'd60, 7'd61, 7'd62, 7'd63, 7'd64);
		hold_off = 1'b1;
		random_items(ITEMS_PER_PHASE);
		drain();

		no_gaps = 1'b1;
		set_buttons(7'd0, 7'd1, 7'd2, 7'd3, 7'd124);
		random_items(ITEMS_PER_PHASE);
		drain();
		no_gaps = 1'b0;

		// top track buttons would lie past note 127
		set_buttons(7'd127, 7'd0, 7'd126, 7'd1, 7'd126);
		random_items(ITEMS_PER_PHASE);
		drain();

		// shared note numbers: the earlier rule must win
		set_buttons(7'd10, 7'd10, 7'd11, 7'd11, 7'd10);
		random_items(ITEMS_PER_PHASE);
		drain();

		set_buttons(any_note(), any_note(), any_note(), any_note(), any_note());
		random_items(ITEMS_PER_PHASE);
		drain();

		if (fail_count == 0 && expected_left == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
